// File: design/spe_pkg.sv
// Package for the sphere point evaluator: word types, defaults and arctangent table.
`default_nettype none
package spe_pkg;
   localparam int ANGLE_BITS_DEF  = 16;
   localparam int TRIG_STAGES_DEF = 16;
   localparam int TRIG_W          = 18;
   localparam int ADDR_W          = 5;
   localparam int DATA_W          = 64;
   localparam int REG_W           = 48;

   localparam logic [1:0] REG_CENTRE = 2'd0;
   localparam logic [1:0] REG_AXIS_X = 2'd1;
   localparam logic [1:0] REG_AXIS_Y = 2'd2;
   localparam logic [1:0] REG_AXIS_Z = 2'd3;

   localparam logic [1:0] KIND_POS = 2'd0;
   localparam logic [1:0] KIND_DU  = 2'd1;
   localparam logic [1:0] KIND_DV  = 2'd2;
   localparam logic [1:0] KIND_DW  = 2'd3;

   localparam logic signed [33:0] CORDIC_K0 = 34'sd652032874;

   typedef struct packed {
      logic [15:0] radius_param;
      logic [15:0] azimuth;
      logic [15:0] elevation;
      logic        with_derivatives;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic [1:0]         vector_kind;
      logic               last_of_run;
   } rsp_word_type;

   typedef logic signed [31:0] coord_type;
   typedef coord_type [2:0]    vec3_type;
   typedef vec3_type [3:0]     vec_set_type;

   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// File: design/spe_cordic.sv
// Pipelined rotation CORDIC giving cosine and sine of a turn fraction in Q4.14.
`default_nettype none
module spe_cordic #(
   parameter int ANGLE_BITS  = spe_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_STAGES = spe_pkg::TRIG_STAGES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              adv,
   input  wire logic [15:0]                       angle,
   output logic signed [spe_pkg::TRIG_W-1:0]      cos_out,
   output logic signed [spe_pkg::TRIG_W-1:0]      sin_out
);
   import spe_pkg::*;

   localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

   logic signed [33:0] x_ff [TRIG_STAGES+1];
   logic signed [33:0] y_ff [TRIG_STAGES+1];
   logic signed [33:0] z_ff [TRIG_STAGES+1];
   logic               neg_ff [TRIG_STAGES+1];
   logic [31:0]        a_mask, a_off, a_adj;
   logic signed [33:0] xf, yf, xr, yr;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;

   always_comb begin
      a_mask = {angle, 16'h0000} & KEEP;
      a_off  = a_mask + 32'h4000_0000;
      a_adj  = a_off[31] ? a_mask + 32'h8000_0000 : a_mask;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]   <= CORDIC_K0;
         y_ff[0]   <= 34'sd0;
         z_ff[0]   <= 34'(signed'(a_adj));
         neg_ff[0] <= a_off[31];
      end
   end

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
      logic signed [33:0] xs, ys, at;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign at = 34'(atan_turn(i));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!z_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + at;
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_comb begin
      xf = neg_ff[TRIG_STAGES] ? -x_ff[TRIG_STAGES] : x_ff[TRIG_STAGES];
      yf = neg_ff[TRIG_STAGES] ? -y_ff[TRIG_STAGES] : y_ff[TRIG_STAGES];
      xr = (xf + 34'sd32768) >>> 16;
      yr = (yf + 34'sd32768) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= xr[TRIG_W-1:0];
         sin_ff <= yr[TRIG_W-1:0];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule
`default_nettype wire

// File: design/spe_vector.sv
// Four-stage frame projection: direction, derivative vectors, radius scaling, centre add.
`default_nettype none
module spe_vector (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [15:0]                   u,
   input  wire logic                          derivs,
   input  wire logic signed [spe_pkg::TRIG_W-1:0] cv,
   input  wire logic signed [spe_pkg::TRIG_W-1:0] sv,
   input  wire logic signed [spe_pkg::TRIG_W-1:0] cw,
   input  wire logic signed [spe_pkg::TRIG_W-1:0] sw,
   input  wire logic [spe_pkg::REG_W-1:0]     centre,
   input  wire logic [spe_pkg::REG_W-1:0]     axis_x,
   input  wire logic [spe_pkg::REG_W-1:0]     axis_y,
   input  wire logic [spe_pkg::REG_W-1:0]     axis_z,
   output logic                               out_valid,
   output logic                               out_derivs,
   output spe_pkg::vec_set_type               out_set
);
   import spe_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic der1_ff, der2_ff, der3_ff, der4_ff;
   logic [15:0] u1_ff, u2_ff;
   logic signed [TRIG_W-1:0] cw1_ff, sw1_ff;
   logic signed [34:0] h1_ff [3];
   logic signed [34:0] g1_ff [3];
   logic signed [53:0] s2_ff [3][3];
   logic signed [31:0] du3_ff [3];
   logic signed [44:0] pl3_ff [3][3];
   logic signed [43:0] ph3_ff [3][3];
   vec_set_type        set4_ff;

   logic signed [34:0] h_in [3];
   logic signed [34:0] g_in [3];
   logic signed [53:0] s_in [3][3];
   logic signed [31:0] du_in [3];
   logic signed [44:0] pl_in [3][3];
   logic signed [43:0] ph_in [3][3];
   vec_set_type        set_in;

   always_comb begin
      logic signed [15:0] ax, ay, az;
      logic signed [29:0] zq;
      logic signed [16:0] us;
      logic signed [59:0] t;
      logic signed [71:0] sum;
      logic signed [31:0] cen;
      for (int k = 0; k < 3; k++) begin
         ax = signed'(axis_x[16*k +: 16]);
         ay = signed'(axis_y[16*k +: 16]);
         az = signed'(axis_z[16*k +: 16]);
         zq = 30'(az) <<< 14;
         h_in[k] = 35'(cv * ax) + 35'(sv * ay);
         g_in[k] = 35'(cv * ay) - 35'(sv * ax);
         s_in[0][k] = 54'(cw1_ff * h1_ff[k]) + 54'(sw1_ff * zq);
         s_in[1][k] = 54'(cw1_ff * g1_ff[k]);
         s_in[2][k] = 54'(cw1_ff * zq) - 54'(sw1_ff * h1_ff[k]);
         t = 60'(s2_ff[0][k]) + 60'sd33554432;
         du_in[k] = t[57:26];
      end
      us = signed'({1'b0, u2_ff});
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            pl_in[j][k] = us * signed'({1'b0, s2_ff[j][k][26:0]});
            ph_in[j][k] = us * signed'(s2_ff[j][k][53:27]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         cen = 32'(signed'(centre[16*k +: 16])) <<< 8;
         set_in[1][k] = du3_ff[k];
         for (int j = 0; j < 3; j++) begin
            sum = (72'(ph3_ff[j][k]) <<< 27) + 72'(pl3_ff[j][k]) + 72'sd8589934592;
            if (j == 0) begin
               set_in[0][k] = cen + sum[65:34];
            end else begin
               set_in[j+1][k] = sum[65:34];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         der1_ff <= derivs;
         der2_ff <= der1_ff;
         der3_ff <= der2_ff;
         der4_ff <= der3_ff;
         u1_ff   <= u;
         u2_ff   <= u1_ff;
         cw1_ff  <= cw;
         sw1_ff  <= sw;
         h1_ff   <= h_in;
         g1_ff   <= g_in;
         s2_ff   <= s_in;
         du3_ff  <= du_in;
         pl3_ff  <= pl_in;
         ph3_ff  <= ph_in;
         set4_ff <= set_in;
      end
   end

   assign out_valid  = v4_ff;
   assign out_derivs = der4_ff;
   assign out_set    = set4_ff;
endmodule
`default_nettype wire

// File: design/spe_emit.sv
// Result buffer that sends a point and its derivative vectors one word per cycle.
`default_nettype none
module spe_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic                 in_derivs,
   input  wire spe_pkg::vec_set_type in_set,
   output logic                      take,
   output logic                      rsp_strobe,
   output spe_pkg::rsp_word_type     rsp_word
);
   import spe_pkg::*;

   logic        buf_valid_ff;
   logic        derivs_ff;
   logic [1:0]  kind_ff;
   vec_set_type set_ff;
   logic        last_now;

   assign last_now = !derivs_ff || (kind_ff == KIND_DW);
   assign take     = !buf_valid_ff || last_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         kind_ff      <= KIND_POS;
      end else if (take) begin
         buf_valid_ff <= in_valid;
         kind_ff      <= KIND_POS;
      end else begin
         kind_ff      <= kind_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         set_ff    <= in_set;
         derivs_ff <= in_derivs;
      end else begin
         set_ff    <= {vec3_type'('0), set_ff[3:1]};
      end
   end

   always_comb begin
      rsp_strobe           = buf_valid_ff;
      rsp_word.vec_x       = set_ff[0][0];
      rsp_word.vec_y       = set_ff[0][1];
      rsp_word.vec_z       = set_ff[0][2];
      rsp_word.vector_kind = kind_ff;
      rsp_word.last_of_run = last_now;
   end
endmodule
`default_nettype wire

// File: design/sphere_point_evaluator.sv
// Top level of the sphere point evaluator: register file, trig pipes, projection, output.
//
//  channel   signals                                   word
//  input     start / busy                              req_word (u, azimuth, elevation, flag)
//  result    rsp_strobe                                rsp_word (x, y, z, kind, last)
//  config    psel penable pwrite paddr pwdata prdata   48-bit frame registers at 8*i
//
// An accepted word passes the trig pipes, the projection and the output buffer.
// A point-only word gives one result word, a word with derivatives four; the output
// buffer sets the rate: one item per cycle unless a derivative run is draining.
// busy rises only while the buffer still drains a run and the pipeline tail is full.
// Synchronous reset clears valid bits and restores the identity frame and zero centre.
`default_nettype none
module sphere_point_evaluator #(
   parameter int ANGLE_BITS  = spe_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_STAGES = spe_pkg::TRIG_STAGES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire spe_pkg::req_word_type         req_word,
   output logic                               busy,
   output logic                               rsp_strobe,
   output spe_pkg::rsp_word_type              rsp_word,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [spe_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [spe_pkg::DATA_W-1:0]    pwdata,
   output logic [spe_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);
   import spe_pkg::*;

   localparam int LAT = TRIG_STAGES + 2;

   logic [REG_W-1:0] centre_ff, axis_x_ff, axis_y_ff, axis_z_ff;
   logic             valid_ff [LAT];
   logic [15:0]      u_ff [LAT];
   logic             der_ff [LAT];
   logic             adv, take, tail_valid, tail_derivs, accept;
   logic [1:0]       reg_idx;
   logic signed [TRIG_W-1:0] cv, sv, cw, sw;
   vec_set_type      tail_set;

   assign reg_idx = paddr[4:3];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff <= 48'd0;
         axis_x_ff <= 48'd16384;
         axis_y_ff <= 48'd1073741824;
         axis_z_ff <= 48'd70368744177664;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_CENTRE: centre_ff <= pwdata[REG_W-1:0];
            REG_AXIS_X: axis_x_ff <= pwdata[REG_W-1:0];
            REG_AXIS_Y: axis_y_ff <= pwdata[REG_W-1:0];
            REG_AXIS_Z: axis_z_ff <= pwdata[REG_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CENTRE: prdata = {16'h0, centre_ff};
         REG_AXIS_X: prdata = {16'h0, axis_x_ff};
         REG_AXIS_Y: prdata = {16'h0, axis_y_ff};
         REG_AXIS_Z: prdata = {16'h0, axis_z_ff};
         default:    prdata = '0;
      endcase
   end

   assign adv    = !tail_valid || take;
   assign busy   = !adv;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= accept;
         for (int i = 1; i < LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff[0]   <= req_word.radius_param;
         der_ff[0] <= req_word.with_derivatives;
         for (int i = 1; i < LAT; i++) begin
            u_ff[i]   <= u_ff[i-1];
            der_ff[i] <= der_ff[i-1];
         end
      end
   end

   spe_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_trig_v (
      .clock   (clock),
      .adv     (adv),
      .angle   (req_word.azimuth),
      .cos_out (cv),
      .sin_out (sv)
   );

   spe_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_trig_w (
      .clock   (clock),
      .adv     (adv),
      .angle   (req_word.elevation),
      .cos_out (cw),
      .sin_out (sw)
   );

   spe_vector u_vector (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (valid_ff[LAT-1]),
      .u          (u_ff[LAT-1]),
      .derivs     (der_ff[LAT-1]),
      .cv         (cv),
      .sv         (sv),
      .cw         (cw),
      .sw         (sw),
      .centre     (centre_ff),
      .axis_x     (axis_x_ff),
      .axis_y     (axis_y_ff),
      .axis_z     (axis_z_ff),
      .out_valid  (tail_valid),
      .out_derivs (tail_derivs),
      .out_set    (tail_set)
   );

   spe_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (tail_valid),
      .in_derivs  (tail_derivs),
      .in_set     (tail_set),
      .take       (take),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.last_of_run |=> rsp_strobe)
      else $error("derivative run broken");

   a_kind_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.last_of_run |=>
         rsp_word.vector_kind == $past(rsp_word.vector_kind) + 2'd1)
      else $error("vector kind out of sequence");

   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> tail_valid && rsp_strobe)
      else $error("busy without a full tail");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.last_of_run |=>
         !rsp_strobe || rsp_word.vector_kind == KIND_POS)
      else $error("new run does not start with the point");
endmodule
`default_nettype wire

// File: sim/tb_sphere_point_evaluator.sv
// Testbench for sphere_point_evaluator: directed table and random words checked against a predictor.
`default_nettype none
module tb_sphere_point_evaluator;
   import spe_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 240;
   localparam int N_ROWS       = 16;

   typedef struct {
      logic [15:0] radius;
      logic [15:0] azim;
      logic [15:0] elev;
      logic        derivs;
      bit          pos_known;
      logic signed [31:0] px, py, pz;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_word_type req_word = '0;
   logic busy;
   logic rsp_strobe;
   rsp_word_type rsp_word;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   sphere_point_evaluator i_dut (
      .clock(clock), .reset(reset), .start(start), .req_word(req_word), .busy(busy),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // frame copy held by the predictor
   logic [REG_W-1:0] frame_regs [0:3];
   rsp_word_type expected_words [$];
   int mismatches = 0;
   int words_in = 0;
   int words_out = 0;
   int frames_used = 0;
   int cycles = 0;
   stim_row_type rows [0:N_ROWS-1];

   localparam longint ATAN_TURN [0:15] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, words_out);
   endtask

   function automatic void sin_cos_turn(input logic [15:0] angle, output longint c,
                                        output longint s);
      logic [31:0] a;
      logic [31:0] t;
      bit flip;
      longint x, y, z, xs, ys;
      a = {angle, 16'h0};
      t = a + 32'h40000000;
      flip = t[31];
      if (flip) a = a + 32'h80000000;
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ATAN_TURN[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ATAN_TURN[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = (x + 32768) >>> 16;
      s = (y + 32768) >>> 16;
   endfunction

   function automatic longint comp16(input logic [REG_W-1:0] pk, input int k);
      logic [15:0] f;
      f = pk[16*k +: 16];
      return longint'($signed(f));
   endfunction

   function automatic void predict_surface_vectors(input req_word_type w);
      longint u, cv, sv, cw, sw, ax, ay, az, h, g, zq, d, ev, ew;
      vec_set_type v;
      rsp_word_type r;
      u = longint'(w.radius_param);
      sin_cos_turn(w.azimuth, cv, sv);
      sin_cos_turn(w.elevation, cw, sw);
      for (int k = 0; k < 3; k++) begin
         ax = comp16(frame_regs[REG_AXIS_X], k);
         ay = comp16(frame_regs[REG_AXIS_Y], k);
         az = comp16(frame_regs[REG_AXIS_Z], k);
         h = cv * ax + sv * ay;
         g = cv * ay - sv * ax;
         zq = az * 16384;
         d = cw * h + sw * zq;
         ev = cw * g;
         ew = cw * zq - sw * h;
         v[KIND_POS][k] = 32'(comp16(frame_regs[REG_CENTRE], k) * 256
                              + ((u * d + (64'sd1 <<< 33)) >>> 34));
         v[KIND_DU][k] = 32'((d + (64'sd1 <<< 25)) >>> 26);
         v[KIND_DV][k] = 32'((u * ev + (64'sd1 <<< 33)) >>> 34);
         v[KIND_DW][k] = 32'((u * ew + (64'sd1 <<< 33)) >>> 34);
      end
      for (int kind = 0; kind < 4; kind++) begin
         if (kind == 0 || w.with_derivatives) begin
            r.vec_x = v[kind][0];
            r.vec_y = v[kind][1];
            r.vec_z = v[kind][2];
            r.vector_kind = 2'(kind);
            r.last_of_run = !w.with_derivatives || kind == 3;
            expected_words.push_back(r);
         end
      end
   endfunction

   always @(negedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         words_out++;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_word.vec_x, 0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.vec_x !== want.vec_x) report_mismatch("vec_x", rsp_word.vec_x, want.vec_x);
            if (rsp_word.vec_y !== want.vec_y) report_mismatch("vec_y", rsp_word.vec_y, want.vec_y);
            if (rsp_word.vec_z !== want.vec_z) report_mismatch("vec_z", rsp_word.vec_z, want.vec_z);
            if (rsp_word.vector_kind !== want.vector_kind)
               report_mismatch("vector_kind", rsp_word.vector_kind, want.vector_kind);
            if (rsp_word.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_word.last_of_run, want.last_of_run);
         end
      end
   end

   // call at a rising edge; returns at the edge that accepted the word
   task automatic send_word(input req_word_type w, input bit pos_known,
                            input logic signed [31:0] px, py, pz);
      rsp_word_type r;
      start <= 1'b1;
      req_word <= w;
      do @(negedge clock); while (busy);
      @(posedge clock);
      words_in++;
      if (pos_known) begin
         r.vec_x = px; r.vec_y = py; r.vec_z = pz;
         r.vector_kind = KIND_POS;
         r.last_of_run = 1'b1;
         expected_words.push_back(r);
      end else begin
         predict_surface_vectors(w);
      end
   endtask

   task automatic write_frame_reg(input logic [1:0] idx, input logic [REG_W-1:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_W'(idx) << 3;
      pwdata <= {$urandom, $urandom} & ~{{(DATA_W-REG_W){1'b0}}, {REG_W{1'b1}}} | value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      frame_regs[idx] = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_and_settle();
      start <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_frame(input logic [REG_W-1:0] c, x, y, z);
      drain_and_settle();
      write_frame_reg(REG_CENTRE, c);
      write_frame_reg(REG_AXIS_X, x);
      write_frame_reg(REG_AXIS_Y, y);
      write_frame_reg(REG_AXIS_Z, z);
      frames_used++;
   endtask

   task automatic random_burst_run(input int n);
      req_word_type w;
      int burst_left;
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         w.radius_param = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 511)) : 16'($urandom);
         w.azimuth = 16'($urandom);
         w.elevation = 16'($urandom);
         w.with_derivatives = 1'($urandom);
         send_word(w, 1'b0, 0, 0, 0);
         if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 9)) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      req_word_type w;
      rows[0]  = '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 0, 0, 0};
      rows[1]  = '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 0, 0, 0};
      rows[2]  = '{16'h0000, 16'h4000, 16'hC000, 1'b1, 1'b0, 0, 0, 0};
      rows[3]  = '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0, 0, 0, 0};
      rows[4]  = '{16'hFFFF, 16'h4000, 16'h0000, 1'b1, 1'b0, 0, 0, 0};
      rows[5]  = '{16'hFFFF, 16'h8000, 16'h0000, 1'b1, 1'b0, 0, 0, 0};
      rows[6]  = '{16'hFFFF, 16'hC000, 16'h0000, 1'b1, 1'b0, 0, 0, 0};
      rows[7]  = '{16'h0100, 16'h2000, 16'h2000, 1'b1, 1'b0, 0, 0, 0};
      rows[8]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 0, 0, 0};
      rows[9]  = '{16'h8000, 16'h0000, 16'h4000, 1'b1, 1'b0, 0, 0, 0};
      rows[10] = '{16'h8000, 16'h0000, 16'hC000, 1'b0, 1'b0, 0, 0, 0};
      rows[11] = '{16'h0001, 16'h7FFF, 16'h8001, 1'b1, 1'b0, 0, 0, 0};
      rows[12] = '{16'h0100, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 0, 0, 0};
      rows[13] = '{16'hFFFF, 16'hBFFF, 16'h3FFF, 1'b1, 1'b0, 0, 0, 0};
      rows[14] = '{16'h0100, 16'h4001, 16'h4000, 1'b1, 1'b0, 0, 0, 0};
      rows[15] = '{16'h00FF, 16'h8000, 16'h8000, 1'b0, 1'b0, 0, 0, 0};

      frame_regs[REG_CENTRE] = 48'h0;
      frame_regs[REG_AXIS_X] = 48'd16384;
      frame_regs[REG_AXIS_Y] = 48'd1073741824;
      frame_regs[REG_AXIS_Z] = 48'd70368744177664;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset frame: directed table then random words
      for (int i = 0; i < N_ROWS; i++) begin
         w.radius_param = rows[i].radius;
         w.azimuth = rows[i].azim;
         w.elevation = rows[i].elev;
         w.with_derivatives = rows[i].derivs;
         send_word(w, rows[i].pos_known, rows[i].px, rows[i].py, rows[i].pz);
      end
      frames_used++;
      random_burst_run(RANDOM_ITEMS / 5);

      // largest positive fields
      load_frame(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
      random_burst_run(RANDOM_ITEMS / 5);
      // most negative fields
      load_frame(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
      random_burst_run(RANDOM_ITEMS / 5);
      // left-handed orthonormal frame, offset centre
      load_frame(48'hFF00_0280_FC40, 48'h0000_4000_0000, 48'h0000_0000_C000, 48'hC000_0000_0000);
      random_burst_run(RANDOM_ITEMS / 5);
      // arbitrary register contents
      load_frame(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      random_burst_run(RANDOM_ITEMS / 5);

      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d words through %0d frame settings, %0d result words checked.",
               words_in, frames_used, words_out);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
